// ----- hdl/gjsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjsp_pkg - shared constants for the grid jump shortest path block
// Register indexes, field widths and move direction codes.
// ----------------------------------------------------------------------------
package gjsp_pkg;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JUMP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ROW     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COL     = 3'd6;

   // result distance and internal distance widths
   localparam int DIST_W    = 12;
   localparam int DM_DIST_W = 13;
   localparam logic [DIST_W-1:0] DIST_SAT = 12'hFFF;

   // move directions, visited in this order
   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

endpackage

// ----- hdl/grid_jump_shortest_path_top.sv -----
`timescale 1ns / 1ps
// A request that is not the last cell of the grid is taken without starting a search.
// The last cell starts a search: clear all 2**(RB+CB) distance entries, seed the start, then
// pop and read each queued cell, step and check each jump step probed, end a direction
// at the edge or the jump limit, and read the end cell; a start or end off the grid answers
// next cycle. One cell per cycle is taken while loading; each csr write, and reset, stalls
// requests for a raster recompute. Reset is synchronous, clears control state only.
// ----------------------------------------------------------------------------
// grid_jump_shortest_path_top - obstacle grid loader and jump BFS solver
// Loads one cell per request in raster order and, on the last cell, runs a
// breadth-first search over RAMs with one shared step unit under a sequencer.
// ----------------------------------------------------------------------------
module grid_jump_shortest_path_top #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_blocked,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_reachable,
   output logic [gjsp_pkg::DIST_W-1:0]       rsp_distance,
   // csr write port
   input  logic                              csr_we,
   input  logic [gjsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gjsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RB + CB;
   localparam int DEPTH = 1 << AW;
   localparam int DMW   = gjsp_pkg::DM_DIST_W;
   localparam int QW    = AW + DMW;
   localparam int CNTW  = 14;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_CLEAR = 4'd2;
   localparam logic [3:0] S_INIT  = 4'd3;
   localparam logic [3:0] S_POP   = 4'd4;
   localparam logic [3:0] S_POPW  = 4'd5;
   localparam logic [3:0] S_STEP  = 4'd6;
   localparam logic [3:0] S_CHK   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_FINW  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
      return {RB'(r), CB'(c)};
   endfunction

   // configuration registers
   logic [6:0] height_ff, width_ff, jump_ff;
   logic [5:0] srow_ff, scol_ff, erow_ff, ecol_ff;

   // loader state
   logic [CNTW-1:0] total_ff, cnt_ff, cnt_in, row_ff, row_in;
   logic [6:0]      col_ff, col_in;

   // divider
   logic            div_pend_ff, div_pend_in;
   logic [3:0]      div_cnt_ff, div_cnt_in;
   logic [CNTW-1:0] div_num_ff, div_num_in, div_quo_ff, div_quo_in;
   logic [6:0]      div_rem_ff, div_rem_in;

   // search state
   logic [3:0]   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW:0]  head_ff, head_in, tail_ff, tail_in;
   logic [6:0]   cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [6:0]   pr_ff, pr_in, pc_ff, pc_in;
   logic [DMW-1:0] nd_ff, nd_in;
   logic [1:0]   dir_ff, dir_in;
   logic [7:0]   k_ff, k_in;
   logic         rsp_reach_ff, rsp_reach_in;
   logic [gjsp_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   // RAM ports
   logic          obs_we, obs_rdata;
   logic [AW-1:0] obs_waddr, obs_raddr;
   logic          dm_we;
   logic [AW-1:0] dm_waddr, dm_raddr;
   logic [DMW:0]  dm_wdata, dm_rdata;
   logic          q_we;
   logic [AW-1:0] q_waddr, q_raddr;
   logic [QW-1:0] q_wdata, q_rdata;

   // effective grid size
   logic [6:0] h_eff, w_eff;
   logic       accept, last_cell, range_bad;
   logic [7:0] rem_sh;
   logic       qbit;
   logic       step_ok;
   logic [6:0] nr, nc;

   always_comb begin
      if (height_ff == 7'd0) begin
         h_eff = 7'd1;
      end else if (32'(height_ff) > MAX_ROWS) begin
         h_eff = 7'(MAX_ROWS);
      end else begin
         h_eff = height_ff;
      end
      if (width_ff == 7'd0) begin
         w_eff = 7'd1;
      end else if (32'(width_ff) > MAX_COLS) begin
         w_eff = 7'(MAX_COLS);
      end else begin
         w_eff = width_ff;
      end
   end

   assign req_ready     = (state_ff == S_IDLE) && !div_pend_ff;
   assign accept        = req_valid && req_ready;
   assign last_cell     = !(({1'b0, cnt_ff} + 15'd1) < {1'b0, total_ff});
   assign range_bad     = ({1'b0, srow_ff} >= h_eff) || ({1'b0, scol_ff} >= w_eff) ||
                          ({1'b0, erow_ff} >= h_eff) || ({1'b0, ecol_ff} >= w_eff);
   assign rsp_valid     = (state_ff == S_OUT);
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_distance  = rsp_dist_ff;

   // divider step and jump step
   assign rem_sh = {div_rem_ff, div_num_ff[CNTW-1]};
   assign qbit   = (rem_sh >= {1'b0, w_eff});

   always_comb begin
      nr = pr_ff;
      nc = pc_ff;
      step_ok = 1'b0;
      case (dir_ff)
         gjsp_pkg::DIR_DOWN: begin
            nr = pr_ff + 7'd1;
            step_ok = (nr < h_eff);
         end
         gjsp_pkg::DIR_UP: begin
            nr = pr_ff - 7'd1;
            step_ok = (pr_ff != 7'd0);
         end
         gjsp_pkg::DIR_RIGHT: begin
            nc = pc_ff + 7'd1;
            step_ok = (nc < w_eff);
         end
         default: begin
            nc = pc_ff - 7'd1;
            step_ok = (pc_ff != 7'd0);
         end
      endcase
      if (k_ff > {1'b0, jump_ff}) begin
         step_ok = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      div_pend_in = csr_we || div_pend_ff;
      div_cnt_in  = div_cnt_ff;
      div_num_in  = div_num_ff;
      div_quo_in  = div_quo_ff;
      div_rem_in  = div_rem_ff;
      clr_in      = clr_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      pr_in       = pr_ff;
      pc_in       = pc_ff;
      nd_in       = nd_ff;
      dir_in      = dir_ff;
      k_in        = k_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_dist_in  = rsp_dist_ff;

      obs_we    = 1'b0;
      obs_waddr = {RB'(row_ff), CB'(col_ff)};
      obs_raddr = cell_addr(nr, nc);
      dm_we     = 1'b0;
      dm_waddr  = clr_ff;
      dm_wdata  = '0;
      dm_raddr  = cell_addr(nr, nc);
      q_we      = 1'b0;
      q_waddr   = tail_ff[AW-1:0];
      q_wdata   = {cell_addr(pr_ff, pc_ff), nd_ff};
      q_raddr   = head_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (div_pend_ff) begin
               // recompute row and column of the load counter
               div_pend_in = csr_we;
               div_num_in  = cnt_ff;
               div_rem_in  = 7'd0;
               div_quo_in  = '0;
               div_cnt_in  = 4'd0;
               state_in    = S_DIV;
            end else if (accept) begin
               obs_we = (cnt_ff < total_ff);
               if (!last_cell) begin
                  cnt_in = cnt_ff + CNTW'(1);
                  if ((col_ff + 7'd1) == w_eff) begin
                     col_in = 7'd0;
                     row_in = row_ff + CNTW'(1);
                  end else begin
                     col_in = col_ff + 7'd1;
                  end
               end else begin
                  cnt_in = '0;
                  row_in = '0;
                  col_in = 7'd0;
                  if (range_bad) begin
                     rsp_reach_in = 1'b0;
                     rsp_dist_in  = '0;
                     state_in     = S_OUT;
                  end else begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
               end
            end
         end
         S_DIV: begin
            div_rem_in = qbit ? 7'(rem_sh - {1'b0, w_eff}) : rem_sh[6:0];
            div_quo_in = {div_quo_ff[CNTW-2:0], qbit};
            div_num_in = {div_num_ff[CNTW-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'(CNTW - 1)) begin
               row_in   = div_quo_in;
               col_in   = div_rem_in;
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            dm_we  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            // start cell at distance zero, first queue entry
            dm_we    = 1'b1;
            dm_waddr = cell_addr({1'b0, srow_ff}, {1'b0, scol_ff});
            dm_wdata = {1'b1, {DMW{1'b0}}};
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = {cell_addr({1'b0, srow_ff}, {1'b0, scol_ff}), {DMW{1'b0}}};
            head_in  = '0;
            tail_in  = (AW+1)'(1);
            state_in = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               state_in = S_FIN;
            end else begin
               head_in  = head_ff + (AW+1)'(1);
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            cur_row_in = 7'(q_rdata[QW-1:DMW+CB]);
            cur_col_in = 7'(q_rdata[DMW+CB-1:DMW]);
            pr_in      = 7'(q_rdata[QW-1:DMW+CB]);
            pc_in      = 7'(q_rdata[DMW+CB-1:DMW]);
            nd_in      = q_rdata[DMW-1:0] + DMW'(1);
            dir_in     = gjsp_pkg::DIR_DOWN;
            k_in       = 8'd1;
            state_in   = S_STEP;
         end
         S_STEP: begin
            if (step_ok) begin
               pr_in    = nr;
               pc_in    = nc;
               state_in = S_CHK;
            end else if (dir_ff == gjsp_pkg::DIR_LEFT) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
               k_in   = 8'd1;
               pr_in  = cur_row_ff;
               pc_in  = cur_col_ff;
            end
         end
         S_CHK: begin
            if (obs_rdata || (dm_rdata[DMW] && (dm_rdata[DMW-1:0] < nd_ff))) begin
               // blocked or already reached closer: this direction ends
               if (dir_ff == gjsp_pkg::DIR_LEFT) begin
                  state_in = S_POP;
               end else begin
                  dir_in   = dir_ff + 2'd1;
                  k_in     = 8'd1;
                  pr_in    = cur_row_ff;
                  pc_in    = cur_col_ff;
                  state_in = S_STEP;
               end
            end else begin
               if (!dm_rdata[DMW]) begin
                  dm_we    = 1'b1;
                  dm_waddr = cell_addr(pr_ff, pc_ff);
                  dm_wdata = {1'b1, nd_ff};
                  if (tail_ff < (AW+1)'(DEPTH)) begin
                     q_we    = 1'b1;
                     tail_in = tail_ff + (AW+1)'(1);
                  end
               end
               k_in     = k_ff + 8'd1;
               state_in = S_STEP;
            end
         end
         S_FIN: begin
            dm_raddr = cell_addr({1'b0, erow_ff}, {1'b0, ecol_ff});
            state_in = S_FINW;
         end
         S_FINW: begin
            rsp_reach_in = dm_rdata[DMW];
            if (!dm_rdata[DMW]) begin
               rsp_dist_in = '0;
            end else if (dm_rdata[DMW-1:0] > DMW'(gjsp_pkg::DIST_SAT)) begin
               rsp_dist_in = gjsp_pkg::DIST_SAT;
            end else begin
               rsp_dist_in = dm_rdata[gjsp_pkg::DIST_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         div_pend_ff <= 1'b1;
         cnt_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= 7'd0;
         head_ff     <= '0;
         tail_ff     <= '0;
         height_ff   <= 7'd64;
         width_ff    <= 7'd64;
         jump_ff     <= 7'd1;
         srow_ff     <= 6'd0;
         scol_ff     <= 6'd0;
         erow_ff     <= 6'd0;
         ecol_ff     <= 6'd0;
      end else begin
         state_ff    <= state_in;
         div_pend_ff <= div_pend_in;
         cnt_ff      <= cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         if (csr_we) begin
            case (csr_index)
               gjsp_pkg::CSR_GRID_HEIGHT: height_ff <= csr_wdata;
               gjsp_pkg::CSR_GRID_WIDTH:  width_ff  <= csr_wdata;
               gjsp_pkg::CSR_MAX_JUMP:    jump_ff   <= csr_wdata;
               gjsp_pkg::CSR_START_ROW:   srow_ff   <= csr_wdata[5:0];
               gjsp_pkg::CSR_START_COL:   scol_ff   <= csr_wdata[5:0];
               gjsp_pkg::CSR_END_ROW:     erow_ff   <= csr_wdata[5:0];
               gjsp_pkg::CSR_END_COL:     ecol_ff   <= csr_wdata[5:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      total_ff     <= CNTW'(h_eff) * CNTW'(w_eff);
      div_cnt_ff   <= div_cnt_in;
      div_num_ff   <= div_num_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      clr_ff       <= clr_in;
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      pr_ff        <= pr_in;
      pc_ff        <= pc_in;
      nd_ff        <= nd_in;
      dir_ff       <= dir_in;
      k_ff         <= k_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   // obstacle map
   gjsp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_obs_ram (
      .clock   (clock),
      .wr_en   (obs_we),
      .wr_addr (obs_waddr),
      .wr_data (req_blocked),
      .rd_addr (obs_raddr),
      .rd_data (obs_rdata)
   );

   // distance map: reached flag and distance
   gjsp_ram #(.WIDTH(DMW + 1), .DEPTH(DEPTH)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   // frontier queue: cell address and its distance
   gjsp_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

`ifndef SYNTHESIS
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= (AW+1)'(DEPTH))
      else $error("queue tail overflow");

   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && last_cell) |=> !req_ready)
      else $error("request taken while search pending");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated");
`endif

endmodule

// ----- hdl/gjsp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjsp_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gjsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
